FILE: rtl/core/ttt_pkg.sv
// ----------------------------------------------------------------------------
// ttt_pkg
// Shared widths and types for the trapezoid travel time core.
// ----------------------------------------------------------------------------
package ttt_pkg;

  localparam int unsigned SPEED_FRAC_BITS = 8;
  localparam int unsigned ACCEL_FRAC_BITS = 12;

  localparam int unsigned SPEED_W = 16;
  localparam int unsigned ACCEL_W = 16;
  localparam int unsigned DIST_W  = 20;
  localparam int unsigned TIME_W  = 24;

  // Dividend, divisor, radicand, root and speed-sum base widths.
  localparam int unsigned NUM_W  = 54;
  localparam int unsigned DEN_W  = 41;
  localparam int unsigned RAD_W  = 58;
  localparam int unsigned ROOT_W = 29;
  localparam int unsigned BASE_W = 29;
  localparam int unsigned REM_W  = ROOT_W + 1;
  localparam int unsigned SQ_W   = ROOT_W + 3;

  // Quotient bits: TIME_W result bits plus one overflow bit.
  localparam int unsigned QB_W   = TIME_W + 1;
  localparam int unsigned DCMP_W = DEN_W + TIME_W;

  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL     = 1'b1;

  localparam logic [SPEED_W-1:0] MAX_SPEED_RST = 16'd10240;
  localparam logic [ACCEL_W-1:0] ACCEL_RST     = 16'd4096;
  localparam logic [TIME_W-1:0]  TIME_MAX      = '1;

  typedef struct packed {
    logic              zero;
    logic              trap;
    logic [NUM_W-1:0]  num;
    logic [DEN_W-1:0]  den;
    logic [BASE_W-1:0] base;
  } job_t;

  typedef struct packed {
    job_t              job;
    logic [ROOT_W-1:0] root;
  } qent_t;

endpackage

FILE: rtl/core/trapezoid_travel_time_core.sv
// Throughput: one transaction per cycle while out_tready is high and the queue
// has room; the 29-stage square root and the 25-stage divider are fully
// pipelined, with a four-entry queue between them.
// Reset (rst_n low, synchronous) empties all stages and the queue and loads
// max_speed = 10240 and acceleration = 4096.
// ----------------------------------------------------------------------------
// trapezoid_travel_time_core
// Travel time of a segment under a trapezoidal or triangular speed profile.
// ----------------------------------------------------------------------------
module trapezoid_travel_time_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [15:0] entry_speed, [31:16] exit_speed, [51:32] distance_m, [55:52] zero
  input  logic [55:0]                    in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [23:0] travel_seconds
  output logic [23:0]                    out_tdata,
  // [0] saturated, [1] cruise_reached
  output logic [1:0]                     out_tuser,
  input  logic                           cfg_we,
  input  logic [ttt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [15:0]                    cfg_wdata
);
  import ttt_pkg::*;

  logic [SPEED_W-1:0] max_speed_r;
  logic [ACCEL_W-1:0] accel_r;

  logic  f_valid, q_full, q_pop, q_not_empty;
  qent_t f_ent, q_ent;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_speed_r <= MAX_SPEED_RST;
      accel_r     <= ACCEL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_SPEED: max_speed_r <= cfg_wdata;
        REG_ACCEL:     accel_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  ttt_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .entry_speed  (in_tdata[15:0]),
    .exit_speed   (in_tdata[31:16]),
    .distance_m   (in_tdata[51:32]),
    .max_speed    (max_speed_r),
    .acceleration (accel_r),
    .out_valid    (f_valid),
    .out_ent      (f_ent),
    .out_full     (q_full)
  );

  ttt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_valid),
    .push_ent  (f_ent),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_ent   (q_ent)
  );

  ttt_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_not_empty    (q_not_empty),
    .q_ent          (q_ent),
    .q_pop          (q_pop),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .travel_seconds (out_tdata),
    .saturated      (out_tuser[0]),
    .cruise_reached (out_tuser[1])
  );

endmodule

FILE: rtl/core/ttt_front.sv
// ----------------------------------------------------------------------------
// ttt_front
// Clamps speeds, forms products, classifies the profile and runs the
// pipelined square root for the triangular case.
// ----------------------------------------------------------------------------
module ttt_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [ttt_pkg::SPEED_W-1:0]  entry_speed,
  input  logic [ttt_pkg::SPEED_W-1:0]  exit_speed,
  input  logic [ttt_pkg::DIST_W-1:0]   distance_m,
  input  logic [ttt_pkg::SPEED_W-1:0]  max_speed,
  input  logic [ttt_pkg::ACCEL_W-1:0]  acceleration,
  output logic                         out_valid,
  output ttt_pkg::qent_t               out_ent,
  input  logic                         out_full
);
  import ttt_pkg::*;

  logic en;

  // Stage 0: clamped operands.
  logic               s0_v_r, s0_zero_r;
  logic [SPEED_W-1:0] s0_vs_r, s0_ve_r, s0_vm_r;
  logic [ACCEL_W-1:0] s0_a_r;
  logic [DIST_W-1:0]  s0_d_r;
  logic [SPEED_W-1:0] vs_c, ve_c;

  // Stage 1: products.
  logic                       s1_v_r, s1_zero_r;
  logic [2*SPEED_W-1:0]       s1_vs2_r, s1_ve2_r, s1_vm2_r, s1_dv1_r, s1_dv2_r;
  logic [ACCEL_W+DIST_W-1:0]  s1_ad_r;
  logic [ACCEL_W+SPEED_W-1:0] s1_av_r;
  logic [ACCEL_W-1:0]         s1_a_r;
  logic [SPEED_W-1:0]         s1_vs_r, s1_ve_r;

  // Stage 2 combinational classification.
  logic [52:0]      ad2;
  logic [32:0]      need_s;
  logic [44:0]      need;
  logic [32:0]      sq_sum, dv_sum;
  job_t             job_c;
  logic [RAD_W-1:0] rad_c;

  // Square root stages; index 0 holds the classified job.
  logic              sq_v_r    [0:ROOT_W];
  job_t              sq_job_r  [0:ROOT_W];
  logic [RAD_W-1:0]  sq_rad_r  [0:ROOT_W];
  logic [REM_W-1:0]  sq_rem_r  [0:ROOT_W];
  logic [ROOT_W-1:0] sq_root_r [0:ROOT_W];

  assign en       = !(sq_v_r[ROOT_W] && out_full);
  assign in_ready = en;

  assign vs_c = (entry_speed > max_speed) ? max_speed : entry_speed;
  assign ve_c = (exit_speed > max_speed) ? max_speed : exit_speed;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
      s1_v_r <= 1'b0;
    end else if (en) begin
      s0_v_r <= in_valid;
      s1_v_r <= s0_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_zero_r <= (max_speed == '0) || (acceleration == '0);
      s0_vs_r   <= vs_c;
      s0_ve_r   <= ve_c;
      s0_vm_r   <= max_speed;
      s0_a_r    <= acceleration;
      s0_d_r    <= distance_m;

      s1_zero_r <= s0_zero_r;
      s1_vs2_r  <= 32'(s0_vs_r) * 32'(s0_vs_r);
      s1_ve2_r  <= 32'(s0_ve_r) * 32'(s0_ve_r);
      s1_vm2_r  <= 32'(s0_vm_r) * 32'(s0_vm_r);
      s1_dv1_r  <= 32'(s0_vm_r - s0_vs_r) * 32'(s0_vm_r - s0_vs_r);
      s1_dv2_r  <= 32'(s0_vm_r - s0_ve_r) * 32'(s0_vm_r - s0_ve_r);
      s1_ad_r   <= 36'(s0_a_r) * 36'(s0_d_r);
      s1_av_r   <= 32'(s0_a_r) * 32'(s0_vm_r);
      s1_a_r    <= s0_a_r;
      s1_vs_r   <= s0_vs_r;
      s1_ve_r   <= s0_ve_r;
    end
  end

  // ad2, need and num are scaled by 2^(ACCEL_FRAC_BITS + 2*SPEED_FRAC_BITS).
  always_comb begin
    ad2    = {s1_ad_r, 17'b0};
    need_s = {s1_vm2_r, 1'b0} - 33'(s1_vs2_r) - 33'(s1_ve2_r);
    need   = {need_s, 12'b0};
    sq_sum = 33'(s1_vs2_r) + 33'(s1_ve2_r);
    dv_sum = 33'(s1_dv1_r) + 33'(s1_dv2_r);

    job_c.zero = s1_zero_r;
    // A tie in the cruise test counts as triangular.
    job_c.trap = !s1_zero_r && (ad2 > 53'(need));
    job_c.num  = 54'(ad2) + 54'({dv_sum, 12'b0});
    job_c.den  = job_c.trap ? {s1_av_r, 9'b0} : DEN_W'({s1_a_r, 8'b0});
    job_c.base = {17'(s1_vs_r) + 17'(s1_ve_r), 12'b0};
    // Only meaningful for triangular items, where it stays below 2^58.
    rad_c      = {sq_sum[32:0], 25'b0} + {ad2[44:0], 13'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r[0] <= 1'b0;
    end else if (en) begin
      sq_v_r[0] <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_job_r[0]  <= job_c;
      sq_rad_r[0]  <= rad_c;
      sq_rem_r[0]  <= '0;
      sq_root_r[0] <= '0;
    end
  end

  // One root bit per stage, restoring digit-by-digit method.
  for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
    logic [SQ_W-1:0]   cur;
    logic [SQ_W-1:0]   trial;
    logic              ge;
    logic [REM_W-1:0]  rem_n;
    logic [ROOT_W-1:0] root_n;

    always_comb begin
      cur    = {sq_rem_r[j], sq_rad_r[j][RAD_W-1 -: 2]};
      trial  = SQ_W'({sq_root_r[j], 2'b01});
      ge     = (cur >= trial);
      rem_n  = ge ? REM_W'(cur - trial) : REM_W'(cur);
      root_n = {sq_root_r[j][ROOT_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[j+1] <= 1'b0;
      end else if (en) begin
        sq_v_r[j+1] <= sq_v_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_job_r[j+1]  <= sq_job_r[j];
        sq_rad_r[j+1]  <= {sq_rad_r[j][RAD_W-3:0], 2'b00};
        sq_rem_r[j+1]  <= rem_n;
        sq_root_r[j+1] <= root_n;
      end
    end
  end

  assign out_valid    = sq_v_r[ROOT_W] && en;
  assign out_ent.job  = sq_job_r[ROOT_W];
  assign out_ent.root = sq_root_r[ROOT_W];

endmodule

FILE: rtl/core/ttt_queue.sv
// ----------------------------------------------------------------------------
// ttt_queue
// Four-entry queue that decouples the classifier from the divider.
// ----------------------------------------------------------------------------
module ttt_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ttt_pkg::qent_t push_ent,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output ttt_pkg::qent_t pop_ent
);
  import ttt_pkg::*;

  localparam int unsigned DEPTH = 4;
  localparam int unsigned PTR_W = $clog2(DEPTH);

  qent_t            mem_r [0:DEPTH-1];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0]   count_r;

  assign full      = (count_r == (PTR_W+1)'(DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_ent   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      if (push && !pop)      count_r <= count_r + (PTR_W+1)'(1);
      else if (!push && pop) count_r <= count_r - (PTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_ent;
  end

endmodule

FILE: rtl/core/ttt_back.sv
// ----------------------------------------------------------------------------
// ttt_back
// Forms the dividend and runs a pipelined restoring divider, one quotient
// bit per stage, with the top bit used as the overflow flag.
// ----------------------------------------------------------------------------
module ttt_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_not_empty,
  input  ttt_pkg::qent_t              q_ent,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ttt_pkg::TIME_W-1:0]  travel_seconds,
  output logic                        saturated,
  output logic                        cruise_reached
);
  import ttt_pkg::*;

  logic             en;
  logic [NUM_W-1:0] num_c;

  logic             dv_v_r    [0:QB_W];
  logic             dv_zero_r [0:QB_W];
  logic             dv_trap_r [0:QB_W];
  logic [NUM_W-1:0] dv_rem_r  [0:QB_W];
  logic [DEN_W-1:0] dv_den_r  [0:QB_W];
  logic [QB_W-1:0]  dv_q_r    [0:QB_W];

  assign en    = !dv_v_r[QB_W] || out_ready;
  assign q_pop = en && q_not_empty;

  // Triangular time is (root - base) / den, clipped at zero.
  always_comb begin
    if (q_ent.job.trap) begin
      num_c = q_ent.job.num;
    end else if (q_ent.root >= q_ent.job.base) begin
      num_c = NUM_W'(q_ent.root - q_ent.job.base);
    end else begin
      num_c = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (en) begin
      dv_v_r[0] <= q_not_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_zero_r[0] <= q_ent.job.zero;
      dv_trap_r[0] <= q_ent.job.trap;
      dv_rem_r[0]  <= num_c;
      dv_den_r[0]  <= q_ent.job.den;
      dv_q_r[0]    <= '0;
    end
  end

  for (genvar i = 0; i < QB_W; i++) begin : g_div
    localparam int unsigned K = QB_W - 1 - i;
    logic [DCMP_W-1:0] dsh;
    logic              ge;
    logic [NUM_W-1:0]  rem_n;

    always_comb begin
      dsh   = DCMP_W'(dv_den_r[i]) << K;
      ge    = (DCMP_W'(dv_rem_r[i]) >= dsh);
      rem_n = ge ? (dv_rem_r[i] - dsh[NUM_W-1:0]) : dv_rem_r[i];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[i+1] <= 1'b0;
      end else if (en) begin
        dv_v_r[i+1] <= dv_v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_zero_r[i+1] <= dv_zero_r[i];
        dv_trap_r[i+1] <= dv_trap_r[i];
        dv_rem_r[i+1]  <= rem_n;
        dv_den_r[i+1]  <= dv_den_r[i];
        dv_q_r[i+1]    <= {dv_q_r[i][QB_W-2:0], ge};
      end
    end
  end

  // A set top quotient bit means the time is at least 2^24 seconds.
  assign out_valid      = dv_v_r[QB_W];
  assign saturated      = dv_zero_r[QB_W] || dv_q_r[QB_W][QB_W-1];
  assign travel_seconds = saturated ? TIME_MAX : dv_q_r[QB_W][TIME_W-1:0];
  assign cruise_reached = dv_trap_r[QB_W] && !dv_zero_r[QB_W];

endmodule

FILE: rtl/core/ttt_checker.sv
// ----------------------------------------------------------------------------
// ttt_checker
// Port-level checks for the trapezoid travel time core.
// ----------------------------------------------------------------------------
module ttt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // A stalled result transaction must hold its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // A saturated result always reports the largest time.
  a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == 24'hFFFFFF)
    else $error("saturated result without maximum time");

  // The pipeline is empty right after reset.
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind trapezoid_travel_time_core ttt_checker u_ttt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

FILE: dv/trapezoid_travel_time_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// trapezoid_travel_time_checker
// Watches the input, result and register-write ports of the travel time core,
// computes the expected travel time of every accepted transaction and compares
// each result transaction with the oldest expected one.
// ----------------------------------------------------------------------------
module trapezoid_travel_time_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  input  logic                          in_tready,
  input  logic [55:0]                   in_tdata,
  input  logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic [23:0]                   out_tdata,
  input  logic [1:0]                    out_tuser,
  input  logic                          cfg_we,
  input  logic [ttt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                   cfg_wdata,
  output int                            pending,
  output int                            fail_count
);
  import ttt_pkg::*;

  typedef struct packed {
    logic [TIME_W-1:0] seconds;
    logic              saturated;
    logic              cruise;
  } travel_t;

  logic [SPEED_W-1:0] max_speed_q;
  logic [ACCEL_W-1:0] accel_q;
  travel_t            travel_q[$];

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic travel_t travel_time(logic [15:0] entry, logic [15:0] exit_s,
                                          logic [19:0] seg_len);
    travel_t     res;
    logic [63:0] v, a, vs, ve, d, ad2, need, num, den, q, root, base, t;
    v  = max_speed_q;
    a  = accel_q;
    vs = entry;
    ve = exit_s;
    d  = seg_len;
    if (v == 0 || a == 0) begin
      res.seconds   = TIME_MAX;
      res.saturated = 1'b1;
      res.cruise    = 1'b0;
      return res;
    end
    if (vs > v) vs = v;
    if (ve > v) ve = v;
    ad2  = (2 * a * d) << (2 * SPEED_FRAC_BITS);
    need = (2 * v * v - vs * vs - ve * ve) << ACCEL_FRAC_BITS;
    if (ad2 > need) begin
      num = ad2 + (((v - vs) * (v - vs) + (v - ve) * (v - ve)) << ACCEL_FRAC_BITS);
      den = (2 * a * v) << SPEED_FRAC_BITS;
      t = num / den;
      res.cruise = 1'b1;
    end else begin
      // The radicand stays below 2^60 here since the cruise test failed.
      q    = ((2 * (vs * vs + ve * ve)) << ACCEL_FRAC_BITS) + 2 * ad2;
      root = int_sqrt(q << ACCEL_FRAC_BITS);
      base = (vs + ve) << ACCEL_FRAC_BITS;
      den  = a << SPEED_FRAC_BITS;
      t = (root >= base) ? (root - base) / den : 0;
      res.cruise = 1'b0;
    end
    if (t > TIME_MAX) begin
      res.seconds   = TIME_MAX;
      res.saturated = 1'b1;
    end else begin
      res.seconds   = t[TIME_W-1:0];
      res.saturated = 1'b0;
    end
    return res;
  endfunction

  assign pending = travel_q.size();

  always @(posedge clk) begin
    travel_t want;
    if (!rst_n) begin
      max_speed_q <= MAX_SPEED_RST;
      accel_q     <= ACCEL_RST;
      travel_q.delete();
      fail_count  <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_MAX_SPEED) max_speed_q <= cfg_wdata;
        else if (cfg_index == REG_ACCEL) accel_q <= cfg_wdata;
      end
      if (in_tvalid && in_tready)
        travel_q.insert(travel_q.size(),
                        travel_time(in_tdata[15:0], in_tdata[31:16], in_tdata[51:32]));
      if (out_tvalid && out_tready) begin
        if (travel_q.size() == 0) begin
          if (fail_count < 10)
            $display("ERROR: unexpected result transaction seconds=%0d flags=%b",
                     out_tdata, out_tuser);
          fail_count <= fail_count + 1;
        end else begin
          want = travel_q.pop_front();
          if (out_tdata !== want.seconds || out_tuser[0] !== want.saturated ||
              out_tuser[1] !== want.cruise) begin
            if (fail_count < 10)
              $display("ERROR: seconds exp %0d got %0d,", want.seconds, out_tdata,
                       " saturated exp %b got %b,", want.saturated, out_tuser[0],
                       " cruise exp %b got %b", want.cruise, out_tuser[1]);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

FILE: dv/trapezoid_travel_time_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// trapezoid_travel_time_core_tb
// Drives directed and random segments through the travel time core under
// several speed and acceleration settings, with random stalls on both sides.
// ----------------------------------------------------------------------------
module trapezoid_travel_time_core_tb;
  import ttt_pkg::*;

  localparam int LATENCY  = 70;
  localparam int IDLE_MAX = 20000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [55:0]          in_tdata = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [23:0]          out_tdata;
  logic [1:0]           out_tuser;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_MAX_SPEED;
  logic [15:0]          cfg_wdata = '0;
  int                   pending;
  int                   fail_count;
  int                   idle_cycles = 0;
  bit                   long_hold = 1'b0;
  bit                   steady = 1'b0;

  always #5 clk = ~clk;

  trapezoid_travel_time_core dut (.*);

  trapezoid_travel_time_checker chk (.*);

  // A watchdog: too long without any transaction ends the run.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_MAX) begin
      $display("FAIL trapezoid_travel_time_core");
      $finish;
    end
  end

  // Result side: mostly ready, short random stalls, now and then a long one.
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
        long_hold = 1'b0;
      end else if (steady || $urandom_range(0, 3) != 0) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b0;
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
        repeat (n) @(posedge clk);
      end
    end
  end

  task automatic send_segment(logic [15:0] entry, logic [15:0] exit_s, logic [19:0] seg_len);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, seg_len, exit_s, entry};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    gap = steady ? 0 : (($urandom_range(0, 19) == 0) ? $urandom_range(8, 40)
                                                     : $urandom_range(0, 2));
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic random_segments(int count);
    logic [15:0] vs, ve;
    logic [19:0] d;
    repeat (count) begin
      vs = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 12000));
      ve = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 12000));
      case ($urandom_range(0, 3))
        0: d = 20'($urandom);
        1: d = 20'($urandom_range(0, 100));
        default: d = 20'($urandom_range(0, 4000));
      endcase
      send_segment(vs, ve, d);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: field extremes, clamping, ties and both profile shapes.
    send_segment(16'd0, 16'd0, 20'd0);
    send_segment(16'hFFFF, 16'hFFFF, 20'hFFFFF);
    send_segment(16'hFFFF, 16'd0, 20'd0);
    send_segment(16'd0, 16'hFFFF, 20'd1);
    send_segment(16'd0, 16'd0, 20'd1600);  // exact tie at default settings
    send_segment(16'd0, 16'd0, 20'd1601);
    send_segment(16'd10240, 16'd10240, 20'd0);
    send_segment(16'd10240, 16'd10240, 20'd1);
    send_segment(16'd10241, 16'd5000, 20'd800);
    send_segment(16'h5555, 16'hAAAA, 20'h55555);
    send_segment(16'hAAAA, 16'h5555, 20'hAAAAA);
    send_segment(16'd1, 16'd2, 20'd3);
    random_segments(30);

    // Receiver holds off while the sender keeps offering, enough to fill the block.
    long_hold = 1'b1;
    random_segments(100);
    drain();

    // Steady stretch with no idling, then the sender waits for every result.
    steady = 1'b1;
    random_segments(40);
    steady = 1'b0;
    drain();

    write_reg(REG_MAX_SPEED, 16'hFFFF);
    write_reg(REG_ACCEL, 16'hFFFF);
    send_segment(16'hFFFF, 16'd0, 20'hFFFFF);
    random_segments(50);
    drain();

    write_reg(REG_MAX_SPEED, 16'd1);
    write_reg(REG_ACCEL, 16'd1);
    send_segment(16'd0, 16'd0, 20'hFFFFF);
    random_segments(50);
    drain();

    write_reg(REG_MAX_SPEED, 16'hFFFF);
    write_reg(REG_ACCEL, 16'd1);
    random_segments(50);
    drain();

    // Zero registers force a saturated result.
    write_reg(REG_MAX_SPEED, 16'd0);
    random_segments(15);
    drain();
    write_reg(REG_MAX_SPEED, 16'd10240);
    write_reg(REG_ACCEL, 16'd0);
    random_segments(15);
    drain();

    repeat (4) begin
      write_reg(REG_MAX_SPEED, 16'($urandom_range(1, 65535)));
      write_reg(REG_ACCEL, 16'($urandom_range(1, 65535)));
      random_segments(40);
      drain();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("PASS trapezoid_travel_time_core");
    end else begin
      $display("FAIL trapezoid_travel_time_core");
    end
    $finish;
  end

endmodule

FILE: trapezoid_travel_time_core.f
rtl/core/ttt_pkg.sv
rtl/core/ttt_front.sv
rtl/core/ttt_queue.sv
rtl/core/ttt_back.sv
rtl/core/trapezoid_travel_time_core.sv
rtl/core/ttt_checker.sv
dv/trapezoid_travel_time_checker.sv
dv/trapezoid_travel_time_core_tb.sv
